### design/uart_receiver_with_fifo_macros.svh
// Assertion macros shared by the receiver modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef UART_RECEIVER_WITH_FIFO_MACROS_SVH
`define UART_RECEIVER_WITH_FIFO_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define URF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define URF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/urf_pkg.sv
// Shared types and constants of the UART receiver with receive FIFO.
// Depends on nothing; used by every module of the block.
package urf_pkg;

  localparam int unsigned DataBits   = 8;
  localparam int unsigned FifoDepth  = 16;
  localparam int unsigned CfgW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CountOutW  = 4;

  localparam logic [CfgW-1:0] BitPeriodReset  = 16'd16;
  localparam logic [CfgW-1:0] StartDelayReset = 16'd24;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBitPeriod  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartDelay = 2'd1;

  // One record per accepted tick, from the receiver to the FIFO side.
  typedef struct packed {
    logic                pop;
    logic                push;
    logic [DataBits-1:0] data;
    logic                receiving;
  } rec_t;

  function automatic logic [CfgW-1:0] at_least_one(input logic [CfgW-1:0] v);
    at_least_one = (v == '0) ? CfgW'(1) : v;
  endfunction

endpackage

### design/urf_rx_front.sv
// Receiver front end: frame timing, bit sampling and configuration registers.
// Depends on urf_pkg; emits one urf_pkg::rec_t per accepted tick.
`include "uart_receiver_with_fifo_macros.svh"

module urf_rx_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [urf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [urf_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                       tick_i,
  input  logic                       rx_line_i,
  input  logic                       pop_req_i,
  output urf_pkg::rec_t              rec_o
);

  localparam int unsigned IdxW = $clog2(urf_pkg::DataBits + 1);

  logic [urf_pkg::CfgW-1:0] bit_period_q, start_delay_q;
  logic                     last_line_q, last_line_d;
  logic                     busy_q, busy_d;
  logic [urf_pkg::CfgW-1:0] timer_q, timer_d, timer_dec;
  logic [IdxW-1:0]          bit_idx_q, bit_idx_d;
  logic [urf_pkg::DataBits-1:0] shift_q, shift_d;
  logic                     push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  <= urf_pkg::BitPeriodReset;
      start_delay_q <= urf_pkg::StartDelayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        urf_pkg::CfgBitPeriod:  bit_period_q  <= cfg_data_i;
        urf_pkg::CfgStartDelay: start_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    last_line_d = rx_line_i;
    busy_d      = busy_q;
    timer_d     = timer_q;
    bit_idx_d   = bit_idx_q;
    shift_d     = shift_q;
    push        = 1'b0;
    timer_dec   = (timer_q != '0) ? timer_q - 1'b1 : timer_q;
    if (!busy_q) begin
      if (last_line_q && !rx_line_i) begin
        busy_d    = 1'b1;
        timer_d   = urf_pkg::at_least_one(start_delay_q);
        bit_idx_d = '0;
        shift_d   = '0;
      end
    end else begin
      timer_d = timer_dec;
      if (timer_dec == '0) begin
        if (bit_idx_q < IdxW'(urf_pkg::DataBits)) begin
          shift_d[bit_idx_q[$clog2(urf_pkg::DataBits)-1:0]] = rx_line_i;
          bit_idx_d = bit_idx_q + 1'b1;
          timer_d   = urf_pkg::at_least_one(bit_period_q);
        end else begin
          // Stop-bit sample: hand the byte over and re-arm right away.
          push      = 1'b1;
          busy_d    = 1'b0;
          bit_idx_d = '0;
          timer_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_line_q <= 1'b1;
      busy_q      <= 1'b0;
      timer_q     <= '0;
      bit_idx_q   <= '0;
      shift_q     <= '0;
    end else if (tick_i) begin
      last_line_q <= last_line_d;
      busy_q      <= busy_d;
      timer_q     <= timer_d;
      bit_idx_q   <= bit_idx_d;
      shift_q     <= shift_d;
    end
  end

  assign rec_o.pop       = pop_req_i;
  assign rec_o.push      = push;
  assign rec_o.data      = shift_q;
  assign rec_o.receiving = busy_d;

  `URF_ASSERT_NOW(a_idle_index_clear, clk_i, rst_ni, !busy_q, bit_idx_q == '0)
  `URF_ASSERT_NOW(a_busy_ends_at_stop, clk_i, rst_ni, $fell(busy_q),
                  $past(bit_idx_q) == IdxW'(urf_pkg::DataBits))

endmodule

### design/urf_rec_queue.sv
// Two-entry queue of tick records between the receiver and the FIFO side.
// Depends on urf_pkg for the record type.
module urf_rec_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  urf_pkg::rec_t in_rec_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output urf_pkg::rec_t out_rec_o
);

  urf_pkg::rec_t entry_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    count_q;
  logic          wr, rd;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign wr          = in_valid_i && in_ready_o;
  assign rd          = out_valid_o && out_ready_i;
  assign out_rec_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      entry_q[wptr_q] <= in_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (wr) wptr_q <= ~wptr_q;
      if (rd) rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

### design/urf_rx_back.sv
// FIFO side: byte store, pop and push in tick order, and the result register.
// Depends on urf_pkg for the record type and output widths.
`include "uart_receiver_with_fifo_macros.svh"

module urf_rx_back #(
  parameter int unsigned FIFO_DEPTH = urf_pkg::FifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rec_valid_i,
  output logic                          rec_ready_o,
  input  urf_pkg::rec_t                 rec_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [urf_pkg::DataBits-1:0]  read_data_o,
  output logic                          read_valid_o,
  output logic [urf_pkg::CountOutW-1:0] byte_count_o,
  output logic                          overflow_o,
  output logic                          receiving_o
);

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned ExtW = (PtrW > urf_pkg::CountOutW) ? PtrW : urf_pkg::CountOutW;
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(FIFO_DEPTH - 1);
  localparam logic [PtrW-1:0] FullCnt  = PtrW'(FIFO_DEPTH - 1);

  logic [urf_pkg::DataBits-1:0] mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q, count_q, count_d, count_mid;
  logic            out_valid_q, rvalid_q, ovf_q, recv_q;
  logic [urf_pkg::DataBits-1:0] rdata_q;
  logic            adv, pop_ok, push_ok;
  logic [ExtW-1:0] count_ext;

  assign rec_ready_o = !out_valid_q || out_ready_i;
  assign adv         = rec_valid_i && rec_ready_o;
  // The pop is served before the push of the same tick.
  assign pop_ok      = rec_i.pop && (count_q != '0);
  assign count_mid   = count_q - PtrW'(pop_ok);
  assign push_ok     = rec_i.push && (count_mid != FullCnt);
  assign count_d     = count_mid + PtrW'(push_ok);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (push_ok) mem_q[wptr_q] <= rec_i.data;
      rdata_q <= pop_ok ? mem_q[rptr_q] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rvalid_q    <= 1'b0;
      ovf_q       <= 1'b0;
      recv_q      <= 1'b0;
    end else begin
      if (adv) begin
        if (pop_ok)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
        if (push_ok) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
        rvalid_q    <= pop_ok;
        ovf_q       <= rec_i.push && !push_ok;
        recv_q      <= rec_i.receiving;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign count_ext    = ExtW'(count_q);
  assign out_valid_o  = out_valid_q;
  assign read_data_o  = rdata_q;
  assign read_valid_o = rvalid_q;
  assign byte_count_o = count_ext[urf_pkg::CountOutW-1:0];
  assign overflow_o   = ovf_q;
  assign receiving_o  = recv_q;

  `URF_ASSERT_NOW(a_ovf_when_full, clk_i, rst_ni, out_valid_q && ovf_q, count_q == FullCnt)
  `URF_ASSERT_NEXT(a_pop_drops_count, clk_i, rst_ni, adv && pop_ok && !push_ok,
                   count_q == $past(count_q) - 1'b1)

endmodule

### design/uart_receiver_with_fifo.sv
// UART 8N1 receiver with receive FIFO; one line sample tick per input transfer.
// Throughput: one tick per cycle while the record queue has room, set by the receiver timer update.
// Path: a tick's record is written into the record queue at its transfer, then taken into
// the FIFO stage's output register and leaves from there; output back-pressure can hold it in the queue.
// Reset is asynchronous, active low, and takes effect at once; no clearing pass.
module uart_receiver_with_fifo #(
  parameter int unsigned FIFO_DEPTH = urf_pkg::FifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [urf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [urf_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          rx_line_i,
  input  logic                          pop_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [urf_pkg::DataBits-1:0]  read_data_o,
  output logic                          read_valid_o,
  output logic [urf_pkg::CountOutW-1:0] byte_count_o,
  output logic                          overflow_o,
  output logic                          receiving_o
);

  urf_pkg::rec_t front_rec, back_rec;
  logic          q_ready, q_valid, back_ready, tick;

  assign in_ready_o = q_ready;
  assign tick       = in_valid_i && q_ready;

  urf_rx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tick_i     (tick),
    .rx_line_i  (rx_line_i),
    .pop_req_i  (pop_req_i),
    .rec_o      (front_rec)
  );

  urf_rec_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (q_ready),
    .in_rec_i    (front_rec),
    .out_valid_o (q_valid),
    .out_ready_i (back_ready),
    .out_rec_o   (back_rec)
  );

  urf_rx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (q_valid),
    .rec_ready_o  (back_ready),
    .rec_i        (back_rec),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .read_valid_o (read_valid_o),
    .byte_count_o (byte_count_o),
    .overflow_o   (overflow_o),
    .receiving_o  (receiving_o)
  );

endmodule

### bench/uart_receiver_with_fifo_checker.sv
// Checker for the UART receiver with receive FIFO: tracks register writes, predicts
// the status of every tick transfer and compares it with the output transfers.
// Depends on urf_pkg for widths, FIFO depth, register indexes and reset values.
`timescale 1ns / 1ps

module uart_receiver_with_fifo_checker
  import urf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 rx_line_i,
  input  logic                 pop_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [DataBits-1:0]  read_data_i,
  input  logic                 read_valid_i,
  input  logic [CountOutW-1:0] byte_count_i,
  input  logic                 overflow_i,
  input  logic                 receiving_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [DataBits-1:0]  data;
    logic                 valid;
    logic [CountOutW-1:0] count;
    logic                 ovf;
    logic                 busy;
  } tick_status_t;

  logic [CfgW-1:0]     bit_period_q;
  logic [CfgW-1:0]     start_delay_q;
  logic                line_prev;
  logic                rx_busy;
  logic [CfgW-1:0]     bit_timer;
  logic [3:0]          bit_cnt;
  logic [DataBits-1:0] shift_q;
  logic [DataBits-1:0] fifo_mem [FifoDepth];
  int unsigned         wr_ptr;
  int unsigned         rd_ptr;
  int unsigned         held;

  tick_status_t tick_status_q[$];
  tick_status_t predicted;
  tick_status_t oldest;

  function automatic logic [CfgW-1:0] timer_load(input logic [CfgW-1:0] v);
    return (v == '0) ? CfgW'(1) : v;
  endfunction

  function automatic int unsigned ring_inc(input int unsigned p);
    return (p == FifoDepth - 1) ? 0 : p + 1;
  endfunction

  // One sample tick: the pop sees the FIFO as it stood before the tick, and a byte
  // finished in the same tick is pushed afterwards.
  task automatic advance_receiver(input logic line, input logic pop,
                                  output tick_status_t res);
    res = '0;
    if (pop && held > 0) begin
      res.data  = fifo_mem[rd_ptr];
      res.valid = 1'b1;
      rd_ptr    = ring_inc(rd_ptr);
      held--;
    end
    if (!rx_busy) begin
      if (line_prev && !line) begin
        rx_busy   = 1'b1;
        bit_timer = timer_load(start_delay_q);
        bit_cnt   = '0;
        shift_q   = '0;
      end
    end else begin
      if (bit_timer != '0) bit_timer--;
      if (bit_timer == '0) begin
        if (bit_cnt < DataBits) begin
          shift_q[bit_cnt[2:0]] = line;
          bit_cnt++;
          bit_timer = timer_load(bit_period_q);
        end else begin
          // Stop-bit sample: the level is not checked and the receiver re-arms here.
          if (held < FifoDepth - 1) begin
            fifo_mem[wr_ptr] = shift_q;
            wr_ptr = ring_inc(wr_ptr);
            held++;
          end else begin
            res.ovf = 1'b1;
          end
          rx_busy   = 1'b0;
          bit_cnt   = '0;
          bit_timer = '0;
        end
      end
    end
    line_prev = line;
    res.count = CountOutW'(held);
    res.busy  = rx_busy;
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors_o++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q  = BitPeriodReset;
      start_delay_q = StartDelayReset;
      line_prev     = 1'b1;
      rx_busy       = 1'b0;
      bit_timer     = '0;
      bit_cnt       = '0;
      shift_q       = '0;
      wr_ptr        = 0;
      rd_ptr        = 0;
      held          = 0;
      tick_status_q.delete();
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgBitPeriod) bit_period_q = cfg_data_i;
        else if (cfg_idx_i == CfgStartDelay) start_delay_q = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (tick_status_q.size() == 0) begin
          errors_o++;
          $display("%0t ns: status expected none, got data %0d valid %0d count %0d",
                   $time, read_data_i, read_valid_i, byte_count_i);
        end else begin
          oldest = tick_status_q.pop_front();
          check_field("read_data", 32'(oldest.data), 32'(read_data_i));
          check_field("read_valid", 32'(oldest.valid), 32'(read_valid_i));
          check_field("byte_count", 32'(oldest.count), 32'(byte_count_i));
          check_field("overflow", 32'(oldest.ovf), 32'(overflow_i));
          check_field("receiving", 32'(oldest.busy), 32'(receiving_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_receiver(rx_line_i, pop_req_i, predicted);
        tick_status_q.push_back(predicted);
      end
      pending_o = tick_status_q.size();
    end
  end

endmodule

### bench/tb_uart_receiver_with_fifo.sv
// Testbench top for the UART receiver with receive FIFO: drives serial frames, noise
// and pops as tick transfers, writes the timing registers and gives the verdict.
// Depends on urf_pkg, the block itself and uart_receiver_with_fifo_checker.
`timescale 1ns / 1ps

module tb_uart_receiver_with_fifo;
  import urf_pkg::*;

  localparam int unsigned ClkPeriod      = 4;
  localparam int unsigned TimeoutCycles  = 3_000_000;
  localparam int unsigned HoldOffCycles  = 120;
  localparam int unsigned TicksPerPhase  = 35;
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 rx_line_i;
  logic                 pop_req_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [DataBits-1:0]  read_data_o;
  logic                 read_valid_o;
  logic [CountOutW-1:0] byte_count_o;
  logic                 overflow_o;
  logic                 receiving_o;

  int unsigned mismatches;
  int unsigned pending;

  // Sender state; steady and hold_off_req are shared with the receiver side.
  logic            steady        = 1'b0;
  logic            hold_off_req  = 1'b0;
  int unsigned     burst_left    = 0;
  int unsigned     ticks_sent    = 0;
  int unsigned     pop_pct       = 0;
  logic [CfgW-1:0] cur_bp        = BitPeriodReset;
  logic [CfgW-1:0] cur_sd        = StartDelayReset;

  uart_receiver_with_fifo uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .rx_line_i, .pop_req_i,
    .out_valid_o, .out_ready_i, .read_data_o, .read_valid_o,
    .byte_count_o, .overflow_o, .receiving_o
  );

  uart_receiver_with_fifo_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .rx_line_i, .pop_req_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .read_data_i(read_data_o), .read_valid_i(read_valid_o),
    .byte_count_i(byte_count_o), .overflow_i(overflow_o),
    .receiving_i(receiving_o),
    .errors_o(mismatches), .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #(ClkPeriod / 2);
    clk_i = 1'b1;
    #(ClkPeriod / 2);
  end

  function automatic int unsigned ticks_of(input logic [CfgW-1:0] v);
    return (v == '0) ? 1 : 32'(v);
  endfunction

  // Offers one tick and returns at the edge where its transfer happens.
  task automatic send_tick(input logic line, input logic pop);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = steady ? 0 : $urandom_range(6, 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_line_i  <= line;
    pop_req_i  <= pop;
    ticks_sent++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_level(input logic line, input int unsigned n, input int unsigned pct);
    repeat (n) send_tick(line, $urandom_range(99, 0) < pct);
  endtask

  // The start run lasts exactly the start delay, so every sample lands on the first
  // tick of its bit and the stop sample is the single stop tick.
  task automatic send_frame(input logic [DataBits-1:0] data, input int unsigned stop_pct);
    int unsigned k;
    send_level(1'b0, ticks_of(cur_sd), pop_pct);
    for (k = 0; k < DataBits; k++) send_level(data[k], ticks_of(cur_bp), pop_pct);
    send_level(1'b1, 1, stop_pct);
  endtask

  // Idle line long enough for any frame in progress to finish.
  task automatic settle();
    send_level(1'b1, ticks_of(cur_sd) + 8 * ticks_of(cur_bp) + 2, pop_pct);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CfgBitPeriod) cur_bp = data;
    else if (idx == CfgStartDelay) cur_sd = data;
  endtask

  task automatic set_timing(input logic [CfgW-1:0] bp, input logic [CfgW-1:0] sd);
    write_reg(CfgBitPeriod, bp);
    write_reg(CfgStartDelay, sd);
  endtask

  // Mostly well-formed frames with random bytes and spacing, mixed with cut-short
  // frames and line noise.
  task automatic run_random(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = ticks_sent + n;
    while (ticks_sent < stop_at) begin
      pop_pct = $urandom_range(60, 10);
      pick = $urandom_range(99, 0);
      send_level(1'b1, $urandom_range(3, 0), pop_pct);
      if (pick < 75) begin
        send_frame(8'($urandom), pop_pct);
      end else begin
        if (pick < 87)
          send_level(1'b0, $urandom_range(ticks_of(cur_sd) + 4 * ticks_of(cur_bp), 1),
                     pop_pct);
        else
          repeat ($urandom_range(15, 4))
            send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
        if ($urandom_range(1, 0) != 0) settle();
      end
    end
  endtask

  // Receiver side: random ready runs and stalls, ready throughout while steady is set, a long hold-off on request.
  initial begin : drain_side
    int unsigned run_left;
    int unsigned hold_left;
    logic rdy_pat;
    run_left    = 0;
    hold_left   = 0;
    rdy_pat     = 1'b1;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          rdy_pat  = ($urandom_range(2, 0) != 0);
          run_left = rdy_pat ? $urandom_range(24, 1) : $urandom_range(6, 1);
        end
        run_left--;
        out_ready_i <= rdy_pat || steady;
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgBitPeriod;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    rx_line_i  = 1'b1;
    pop_req_i  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero timing registers act as one tick, so a frame takes ten ticks.
    set_timing('0, '0);
    send_level(1'b1, 1, 100);
    pop_pct = 0;
    send_frame(8'h00, 0);
    send_frame(8'hFF, 0);
    send_level(1'b1, 3, 100);
    write_reg(CfgSpareIdx, '1);

    // Fill the FIFO, push into a full FIFO that is popped in the same tick, then
    // overflow, and drain it past empty.
    repeat (FifoDepth - 1) send_frame(8'($urandom), 0);
    send_frame(8'($urandom), 100);
    send_frame(8'($urandom), 0);
    send_level(1'b1, FifoDepth, 100);

    set_timing(16'd4, 16'd6);
    hold_off_req = 1'b1;
    run_random(TicksPerPhase);
    settle();
    set_timing(16'd5, 16'd4);
    run_random(TicksPerPhase);
    settle();
    set_timing(CfgW'($urandom_range(12, 4)), CfgW'($urandom_range(20, 4)));
    run_random(TicksPerPhase);
    settle();

    // A long start delay with both sides running without gaps.
    steady  = 1'b1;
    pop_pct = 5;
    set_timing(16'd6, 16'd33);
    send_level(1'b1, 2, pop_pct);
    send_frame(8'($urandom), 50);
    steady = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/urf_pkg.sv
design/urf_rx_front.sv
design/urf_rec_queue.sv
design/urf_rx_back.sv
design/uart_receiver_with_fifo.sv
bench/uart_receiver_with_fifo_checker.sv
bench/tb_uart_receiver_with_fifo.sv
